@@ design/tddbm_pkg.sv @@
// Package for the two-digit display blink multiplexer.
// Holds the mode codes, reset constants, item and result types and the digit split.
// Depends on nothing; used by tddbm_ctrl and the top level.
package tddbm_pkg;

  localparam int unsigned ValueWidth = 7;
  localparam int unsigned CodeWidth  = 4;
  localparam int unsigned CountWidth = 8;

  localparam logic [CountWidth-1:0] HALF_PERIOD_RESET  = 8'd200;
  localparam logic [CountWidth-1:0] BLINK_HALVES_RESET = 8'd5;

  // Register indexes on the configuration port.
  localparam logic REG_HALF_PERIOD  = 1'b0;
  localparam logic REG_BLINK_HALVES = 1'b1;

  // Display modes, one-hot.
  typedef enum logic [3:0] {
    MODE_OFF        = 4'b0001,
    MODE_ON         = 4'b0010,
    MODE_BLINK_DARK = 4'b0100,
    MODE_BLINK_LIT  = 4'b1000
  } mode_t;

  // One input tick.
  typedef struct packed {
    logic [ValueWidth-1:0] shown_value;
    logic                  sample_done;
    logic                  power_button;
    logic                  up_button;
    logic                  down_button;
  } item_t;

  // One result.
  typedef struct packed {
    logic [CodeWidth-1:0] digit_code;
    logic                 tens_enable;
    logic                 ones_enable;
  } result_t;

  // Tens digit of a 7-bit value by reciprocal multiplication (exact for every 7-bit value).
  function automatic logic [CodeWidth-1:0] tens_of(input logic [ValueWidth-1:0] v);
    logic [ValueWidth+8-1:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

  // Ones digit: the value less ten times its tens digit.
  function automatic logic [CodeWidth-1:0] ones_of(input logic [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] t;
    logic [ValueWidth-1:0] r;
    t = {3'd0, tens_of(v)};
    r = v - ((t << 3) + (t << 1));
    return r[CodeWidth-1:0];
  endfunction

endpackage

@@ design/tddbm_ctrl.sv @@
// Mode, blink counters and digit selection for the display multiplexer.
// Updates its state once per processed tick and produces the result for it.
// Depends on tddbm_pkg.
module tddbm_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  tddbm_pkg::item_t         item,
  input  logic [7:0]               half_period_ticks,
  input  logic [7:0]               blink_halves,
  output tddbm_pkg::result_t       result
);
  import tddbm_pkg::*;

  mode_t                 mode;
  mode_t                 mode_next;
  logic                  next_digit_is_ones;
  logic                  next_digit_is_ones_next;
  logic [CountWidth-1:0] half_tick_count;
  logic [CountWidth-1:0] half_tick_count_next;
  logic [CountWidth-1:0] halves_left;
  logic [CountWidth-1:0] halves_left_next;
  logic [CodeWidth-1:0]  held_code;
  logic [CodeWidth-1:0]  held_code_next;

  // Button handling, then the tick action for the resulting mode.
  always_comb begin
    mode_t                 mode_a;
    mode_t                 other;
    logic [CountWidth-1:0] htc_a;
    logic [CountWidth-1:0] hl_a;
    logic [CountWidth-1:0] t_dec;
    logic [CountWidth-1:0] h_dec;
    logic                  drive;
    logic                  count;

    mode_a = mode;
    htc_a  = half_tick_count;
    hl_a   = halves_left;
    if (item.sample_done) begin
      if (item.power_button) begin
        mode_a = (mode == MODE_OFF) ? MODE_ON : MODE_OFF;
      end else if ((item.up_button || item.down_button) && mode != MODE_OFF) begin
        mode_a = (mode == MODE_BLINK_DARK) ? MODE_BLINK_LIT : MODE_BLINK_DARK;
        htc_a  = half_period_ticks;
        hl_a   = blink_halves;
      end
    end

    drive = 1'b0;
    count = 1'b0;
    other = MODE_BLINK_DARK;
    case (mode_a)
      MODE_ON: begin
        drive = 1'b1;
      end
      MODE_BLINK_DARK: begin
        count = 1'b1;
        other = MODE_BLINK_LIT;
      end
      MODE_BLINK_LIT: begin
        drive = 1'b1;
        count = 1'b1;
        other = MODE_BLINK_DARK;
      end
      default: begin
        drive = 1'b0;
      end
    endcase

    // Digit drive alternates between tens and ones.
    held_code_next          = held_code;
    next_digit_is_ones_next = next_digit_is_ones;
    result.tens_enable      = 1'b0;
    result.ones_enable      = 1'b0;
    if (drive) begin
      held_code_next          = next_digit_is_ones ? ones_of(item.shown_value)
                                                   : tens_of(item.shown_value);
      result.tens_enable      = !next_digit_is_ones;
      result.ones_enable      = next_digit_is_ones;
      next_digit_is_ones_next = !next_digit_is_ones;
    end
    result.digit_code = held_code_next;

    // Half-period counting; a zero register value wraps and acts as 256.
    mode_next            = mode_a;
    half_tick_count_next = htc_a;
    halves_left_next     = hl_a;
    t_dec                = htc_a - 8'd1;
    h_dec                = hl_a - 8'd1;
    if (count) begin
      half_tick_count_next = t_dec;
      if (t_dec == '0) begin
        half_tick_count_next = half_period_ticks;
        halves_left_next     = h_dec;
        if (h_dec == '0) begin
          halves_left_next = blink_halves;
          mode_next        = MODE_ON;
        end else begin
          mode_next = other;
        end
      end
    end
  end

  // State registers advance once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_OFF;
      next_digit_is_ones <= 1'b0;
      half_tick_count    <= HALF_PERIOD_RESET;
      halves_left        <= BLINK_HALVES_RESET;
      held_code          <= '0;
    end else if (step) begin
      mode               <= mode_next;
      next_digit_is_ones <= next_digit_is_ones_next;
      half_tick_count    <= half_tick_count_next;
      halves_left        <= halves_left_next;
      held_code          <= held_code_next;
    end
  end

endmodule

@@ design/two_digit_display_blink_mux_core.sv @@
// Two-digit multiplexed display driver with power toggle and blinking.
// The result is registered; the mode and counter update is a single pass of logic.
// Throughput: one tick per cycle while the output is not stalled.
// Reset (synchronous, active high) empties both stages, sets the mode to off, the
// counters and registers to their defaults (200 and 5) and the held code to zero.
// Depends on tddbm_pkg and tddbm_ctrl.
module two_digit_display_blink_mux_core (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tddbm_pkg::ValueWidth-1:0]  shown_value,
  input  logic                              sample_done,
  input  logic                              power_button,
  input  logic                              up_button,
  input  logic                              down_button,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tddbm_pkg::CodeWidth-1:0]   digit_code,
  output logic                              tens_enable,
  output logic                              ones_enable,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import tddbm_pkg::*;

  logic [CountWidth-1:0] half_period_ticks;
  logic [CountWidth-1:0] blink_halves;
  item_t                 in_item;
  logic                  in_full;
  result_t               res;
  result_t               res_next;
  logic                  res_full;
  logic                  advance;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      blink_halves      <= BLINK_HALVES_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HALF_PERIOD:  half_period_ticks <= pwdata[CountWidth-1:0];
        REG_BLINK_HALVES: blink_halves      <= pwdata[CountWidth-1:0];
        default:          half_period_ticks <= half_period_ticks;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_PERIOD:  prdata = {24'd0, half_period_ticks};
      REG_BLINK_HALVES: prdata = {24'd0, blink_halves};
      default:          prdata = '0;
    endcase
  end

  // The input register moves on whenever the result register is free or being emptied.
  assign advance  = !res_full || !out_stall;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item <= '{shown_value:  shown_value,
                   sample_done:  sample_done,
                   power_button: power_button,
                   up_button:    up_button,
                   down_button:  down_button};
    end
  end

  // Mode and digit logic between the two registers.
  tddbm_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .step              (in_full && advance),
    .item              (in_item),
    .half_period_ticks (half_period_ticks),
    .blink_halves      (blink_halves),
    .result            (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      res <= res_next;
    end
  end

  assign out_valid   = res_full;
  assign digit_code  = res.digit_code;
  assign tens_enable = res.tens_enable;
  assign ones_enable = res.ones_enable;

endmodule
